FILE: rtl/core/multichannel_gain_mixer_defines.svh
// ---------------------------------------------------------------------------
// multichannel_gain_mixer_defines.svh
// Assertion macros shared by the mixer RTL.
// ---------------------------------------------------------------------------
`ifndef MULTICHANNEL_GAIN_MIXER_DEFINES_SVH
`define MULTICHANNEL_GAIN_MIXER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MCGM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MCGM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mcgm_pkg.sv
// ---------------------------------------------------------------------------
// mcgm_pkg
// Types, constants and saturation helpers for the gain mixer.
// ---------------------------------------------------------------------------
package mcgm_pkg;

    localparam int CHANNELS_DEF = 9;
    localparam int SAMPLE_W     = 16;
    localparam int GAIN_W       = 32;
    localparam int CH_W         = 4;
    localparam int GAIN_SHIFT   = 16;
    localparam int PROD_W       = GAIN_W + SAMPLE_W;

    localparam logic MODE_MIX  = 1'b0;
    localparam logic MODE_GAIN = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [GAIN_W-1:0]   gain_t;
    typedef logic        [CH_W-1:0]     chan_t;
    typedef logic signed [PROD_W-1:0]   prod_t;

    localparam gain_t UNITY_GAIN = gain_t'(65536);

    // gained sample on its way to the accumulator
    typedef struct packed {
        logic    valid;
        logic    pres;
        logic    last;
        sample_t value;
    } mcgm_stage_t;

    // floor shift by GAIN_SHIFT, then clamp to 16 bits
    function automatic sample_t scale_sat(input prod_t p);
        logic [PROD_W-GAIN_SHIFT-SAMPLE_W:0] top_bits;
        top_bits = p[PROD_W-1:GAIN_SHIFT+SAMPLE_W-1];
        if ((&top_bits) || !(|top_bits))
            return p[GAIN_SHIFT+SAMPLE_W-1:GAIN_SHIFT];
        else if (p[PROD_W-1])
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
    endfunction

    function automatic sample_t add_sat(input sample_t a, input sample_t b);
        logic signed [SAMPLE_W:0] s;
        s = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
        if (s[SAMPLE_W] == s[SAMPLE_W-1])
            return s[SAMPLE_W-1:0];
        else if (s[SAMPLE_W])
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
    endfunction

endpackage

FILE: rtl/core/mcgm_if.sv
// ---------------------------------------------------------------------------
// mcgm_if
// Valid/ready channels of the mixer: item input and mixed-sample output.
// ---------------------------------------------------------------------------
interface mcgm_in_if
    import mcgm_pkg::*;
();
    logic    valid;
    logic    ready;
    logic    mode;
    chan_t   channel;
    gain_t   gain_value;
    sample_t sample;
    logic    present;
    logic    last;

    modport source (output valid, mode, channel, gain_value, sample, present, last,
                    input ready);
    modport sink   (input valid, mode, channel, gain_value, sample, present, last,
                    output ready);
endinterface

interface mcgm_out_if
    import mcgm_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t mixed_sample;

    modport source (output valid, mixed_sample, input ready);
    modport sink   (input valid, mixed_sample, output ready);
endinterface

FILE: rtl/core/mcgm_gain_table.sv
// ---------------------------------------------------------------------------
// mcgm_gain_table
// Per-channel Q16.16 gains, unity after reset; one write and one read port.
// ---------------------------------------------------------------------------
module mcgm_gain_table
    import mcgm_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  chan_t wr_ch,
    input  gain_t wr_gain,
    input  chan_t rd_ch,
    output gain_t rd_gain,
    output logic  rd_ok
);
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    gain_t gain_reg [CHANNELS];
    logic  wr_ok;

    assign wr_ok = {1'b0, wr_ch} < (CH_W+1)'(CHANNELS);
    assign rd_ok = {1'b0, rd_ch} < (CH_W+1)'(CHANNELS);
    assign rd_gain = rd_ok ? gain_reg[rd_ch[IDX_W-1:0]] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
                gain_reg[i] <= UNITY_GAIN;
        end
        else if (wr_en && wr_ok)
        begin
            gain_reg[wr_ch[IDX_W-1:0]] <= wr_gain;
        end
    end

endmodule

FILE: rtl/core/mcgm_scale.sv
// ---------------------------------------------------------------------------
// mcgm_scale
// Input register, then gain multiply with floor shift and 16-bit clamp.
// ---------------------------------------------------------------------------
module mcgm_scale
    import mcgm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  gain_t       gain,
    input  sample_t     sample,
    input  logic        pres,
    input  logic        last,
    input  logic        take,
    output logic        ready,
    output mcgm_stage_t st
);
    logic        v1_reg, v1_next;
    gain_t       gain_reg;
    sample_t     sample_reg;
    logic        pres1_reg, last1_reg;
    logic        v2_reg, v2_next;
    logic        pres2_reg, last2_reg;
    sample_t     value_reg;
    logic        adv1;
    prod_t       prod;

    assign adv1    = v1_reg && (!v2_reg || take);
    assign ready   = !v1_reg || adv1;
    assign v1_next = load || (v1_reg && !adv1);
    assign v2_next = adv1 || (v2_reg && !take);
    assign prod    = prod_t'(gain_reg) * prod_t'(sample_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            gain_reg   <= gain;
            sample_reg <= sample;
            pres1_reg  <= pres;
            last1_reg  <= last;
        end
        if (adv1)
        begin
            pres2_reg <= pres1_reg;
            last2_reg <= last1_reg;
            value_reg <= pres1_reg ? scale_sat(prod) : '0;
        end
    end

    assign st.valid = v2_reg;
    assign st.pres  = pres2_reg;
    assign st.last  = last2_reg;
    assign st.value = value_reg;

endmodule

FILE: rtl/core/mcgm_accum.sv
// ---------------------------------------------------------------------------
// mcgm_accum
// Saturating running sum; emits the mix at the end of a sample time.
// ---------------------------------------------------------------------------
module mcgm_accum
    import mcgm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mcgm_stage_t       st,
    output logic              take,
    mcgm_out_if.source        mix
);
    sample_t acc_reg, acc_next;
    logic    any_reg, any_next;
    logic    out_valid_reg, out_valid_next;
    sample_t out_data_reg;
    sample_t sum;
    logic    emit;

    assign sum  = st.pres ? add_sat(acc_reg, st.value) : acc_reg;
    assign emit = st.last && (any_reg || st.pres);
    assign take = st.valid && (!emit || !out_valid_reg || mix.ready);

    always_comb
    begin
        acc_next       = acc_reg;
        any_next       = any_reg;
        out_valid_next = out_valid_reg && !mix.ready;
        if (take)
        begin
            if (st.last)
            begin
                acc_next = '0;
                any_next = 1'b0;
            end
            else
            begin
                acc_next = sum;
                any_next = any_reg || st.pres;
            end
            if (emit)
                out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            any_reg       <= any_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
            out_data_reg <= sum;
    end

    assign mix.valid        = out_valid_reg;
    assign mix.mixed_sample = out_data_reg;

endmodule

FILE: rtl/core/multichannel_gain_mixer.sv
// ---------------------------------------------------------------------------
// multichannel_gain_mixer
// Per-channel gain, saturating mix of up to CHANNELS streams.
//
//   channel   dir   payload
//   samples   in    mode, channel, gain_value, sample, present, last
//   mix       out   mixed_sample
//
// One request per cycle unless a stalled output holds the pipeline.
// Stages: input register, multiply/clamp register, accumulator + output reg.
// Gain writes land in the table at acceptance and take no pipeline slot.
// Reset restores unity gains and clears the running sum.
// Only an emitting request waits on a stalled output; ready falls when
// both pipeline stages are held behind it.
// ---------------------------------------------------------------------------
`include "multichannel_gain_mixer_defines.svh"

module multichannel_gain_mixer
    import mcgm_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    mcgm_in_if.sink    samples,
    mcgm_out_if.source mix
);
    logic        accept;
    logic        gain_wr;
    logic        load;
    gain_t       rd_gain;
    logic        rd_ok;
    logic        take;
    logic        ready;
    mcgm_stage_t st;

    assign samples.ready = ready;
    assign accept  = samples.valid && ready;
    assign gain_wr = accept && (samples.mode == MODE_GAIN);
    assign load    = accept && (samples.mode == MODE_MIX);

    mcgm_gain_table #(
        .CHANNELS (CHANNELS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (gain_wr),
        .wr_ch   (samples.channel),
        .wr_gain (samples.gain_value),
        .rd_ch   (samples.channel),
        .rd_gain (rd_gain),
        .rd_ok   (rd_ok)
    );

    mcgm_scale u_scale (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .gain   (rd_gain),
        .sample (samples.sample),
        .pres   (samples.present && rd_ok),
        .last   (samples.last),
        .take   (take),
        .ready  (ready),
        .st     (st)
    );

    mcgm_accum u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .take  (take),
        .mix   (mix)
    );

    `MCGM_ASSERT_NEXT(a_emit_shows, take && st.last && st.pres, mix.valid, "mix result not shown")
    `MCGM_ASSERT_NOW(a_stall_cause, st.valid && !take, mix.valid && !mix.ready, "spurious stall")
    `MCGM_ASSERT_NOW(a_full_pipe, !ready, st.valid && !take, "ready low with free stage")

endmodule

FILE: tb/multichannel_gain_mixer_tb.sv
// ----------------------------------------------------------------------------
// multichannel_gain_mixer_tb
// Self-checking bench for the nine-channel saturating gain mixer.
// A shadow of the gain table and the running mix predicts every mixed
// sample. A scoreboard checks each sample the block hands out, in order.
// Stimulus runs in stages: directed corner cases, then well-formed sample
// times with random gains, then stretches at full rate. A long output stall,
// pauses until drained, unstructured random requests and more frames follow.
// ----------------------------------------------------------------------------
module multichannel_gain_mixer_tb
    import mcgm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int      N_CH         = CHANNELS_DEF;
    localparam int      CYCLE_LIMIT  = 200_000;
    localparam int      HOLD_LEN     = 300;
    localparam int      DRAIN_CYCLES = 12;
    localparam int      IDLE_PCT     = 15;
    localparam sample_t SAMPLE_MAX   = sample_t'(16'h7fff);
    localparam sample_t SAMPLE_MIN   = sample_t'(16'h8000);

    typedef struct {
        logic    mode;
        chan_t   channel;
        gain_t   gain_value;
        sample_t sample;
        logic    present;
        logic    last;
    } mix_req_t;

    logic clk;
    logic rst_n;

    mcgm_in_if  samples_if();
    mcgm_out_if mix_if();

    multichannel_gain_mixer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .mix     (mix_if)
    );

    gain_t   gain_shadow [N_CH];
    sample_t mix_sum;
    logic    mix_heard;
    sample_t pending_mixes [$];

    int errors;
    int cycle_count;
    int hold_requests;
    bit steady;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic sample_t clamp_sample(input longint v);
        if (v > longint'(SAMPLE_MAX))
            return SAMPLE_MAX;
        if (v < longint'(SAMPLE_MIN))
            return SAMPLE_MIN;
        return sample_t'(v);
    endfunction

    // floor shift of the full product, then clamp
    function automatic sample_t apply_gain(input gain_t g, input sample_t s);
        longint prod;
        prod = longint'(g) * longint'(s);
        return clamp_sample(prod >>> GAIN_SHIFT);
    endfunction

    function automatic void predict_mix(input mix_req_t r);
        if (r.mode == MODE_GAIN)
        begin
            if (r.channel < N_CH)
                gain_shadow[r.channel] = r.gain_value;
            return;
        end
        if (r.present && r.channel < N_CH)
        begin
            mix_sum   = clamp_sample(longint'(mix_sum) +
                                     longint'(apply_gain(gain_shadow[r.channel], r.sample)));
            mix_heard = 1'b1;
        end
        if (r.last)
        begin
            if (mix_heard)
                pending_mixes.push_back(mix_sum);
            mix_sum   = '0;
            mix_heard = 1'b0;
        end
    endfunction

    function automatic sample_t pick_sample();
        case ($urandom_range(9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return sample_t'(int'($urandom_range(2000)) - 1000);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic gain_t pick_gain();
        case ($urandom_range(9))
            0: return UNITY_GAIN;
            1: return '0;
            2: return gain_t'($urandom);
            3: return -UNITY_GAIN;
            default: return gain_t'($urandom_range(2 * 65536)) - UNITY_GAIN;
        endcase
    endfunction

    // leaves valid high after acceptance; idle_input or an idle pause in the next call lowers it
    task automatic send_item(input mix_req_t r);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            samples_if.valid <= 1'b0;
            @(posedge clk);
        end
        samples_if.valid      <= 1'b1;
        samples_if.mode       <= r.mode;
        samples_if.channel    <= r.channel;
        samples_if.gain_value <= r.gain_value;
        samples_if.sample     <= r.sample;
        samples_if.present    <= r.present;
        samples_if.last       <= r.last;
        do
            @(posedge clk);
        while (samples_if.ready !== 1'b1);
        predict_mix(r);
    endtask

    task automatic send_gain(input chan_t ch, input gain_t g);
        mix_req_t r;
        r = '{mode: MODE_GAIN, channel: ch, gain_value: g, sample: sample_t'($urandom),
              present: 1'($urandom), last: 1'($urandom)};
        send_item(r);
    endtask

    task automatic send_sample(input chan_t ch, input sample_t s, input logic pres,
                               input logic last);
        mix_req_t r;
        r = '{mode: MODE_MIX, channel: ch, gain_value: gain_t'($urandom), sample: s,
              present: pres, last: last};
        send_item(r);
    endtask

    task automatic idle_input();
        samples_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        idle_input();
        while (pending_mixes.size() != 0)
            @(posedge clk);
    endtask

    // one sample time in channel order, sometimes preceded by gain updates
    task automatic send_frame();
        int pct;
        int writes;
        pct    = $urandom_range(100);
        writes = ($urandom_range(9) < 3) ? $urandom_range(1, 2) : 0;
        repeat (writes)
            send_gain(chan_t'($urandom_range(N_CH - 1)), pick_gain());
        for (int ch = 0; ch < N_CH; ch++)
            send_sample(chan_t'(ch), pick_sample(), $urandom_range(99) < pct, ch == N_CH - 1);
    endtask

    task automatic test_directed_cases();
        send_sample(0, SAMPLE_MAX, 1'b1, 1'b0);
        send_sample(1, SAMPLE_MAX, 1'b1, 1'b1);
        send_sample(0, SAMPLE_MIN, 1'b1, 1'b0);
        send_sample(3, SAMPLE_MIN, 1'b1, 1'b0);
        send_sample(8, 5, 1'b0, 1'b1);
        send_sample(2, 123, 1'b0, 1'b1);
        send_gain(0, gain_t'(32'h7fff_ffff));
        send_gain(1, gain_t'(32'h8000_0000));
        send_gain(2, '0);
        send_gain(3, -UNITY_GAIN);
        send_gain(12, '0);
        send_sample(0, 1, 1'b1, 1'b0);
        send_sample(1, -1, 1'b1, 1'b0);
        send_sample(2, SAMPLE_MAX, 1'b1, 1'b0);
        send_sample(3, 7, 1'b1, 1'b0);
        send_sample(15, 1000, 1'b1, 1'b1);
        send_sample(2, SAMPLE_MIN, 1'b1, 1'b1);
        send_gain(4, gain_t'(32768));
        send_sample(4, -1, 1'b1, 1'b1);
        send_sample(9, 100, 1'b1, 1'b1);
        wait_drained();
    endtask

    task automatic test_sample_frames(input int frames);
        repeat (frames)
            send_frame();
        idle_input();
    endtask

    task automatic test_full_rate(input int frames);
        steady = 1'b1;
        repeat (frames)
            send_frame();
        idle_input();
        steady = 1'b0;
    endtask

    task automatic test_output_stall(input int frames);
        hold_requests++;
        repeat (frames)
            send_frame();
        idle_input();
    endtask

    task automatic test_drain_between_frames(input int frames);
        repeat (frames)
        begin
            send_frame();
            wait_drained();
        end
    endtask

    task automatic test_random_items(input int n);
        mix_req_t r;
        repeat (n)
        begin
            r.mode       = ($urandom_range(9) < 3) ? MODE_GAIN : MODE_MIX;
            r.channel    = chan_t'($urandom_range(15));
            r.gain_value = pick_gain();
            r.sample     = pick_sample();
            r.present    = 1'($urandom);
            r.last       = $urandom_range(3) == 0;
            send_item(r);
        end
        idle_input();
    endtask

    // mixed-sample scoreboard and output ready
    initial
    begin
        int hold_served;
        int hold_left;
        sample_t want;
        hold_served  = 0;
        hold_left    = 0;
        mix_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (mix_if.valid === 1'b1 && mix_if.ready === 1'b1)
            begin
                if (pending_mixes.size() == 0)
                begin
                    $error("mixed_sample: expected none, got %0d", mix_if.mixed_sample);
                    errors++;
                end
                else
                begin
                    want = pending_mixes.pop_front();
                    if (mix_if.mixed_sample !== want)
                    begin
                        $error("mixed_sample: expected %0d, got %0d", want,
                               mix_if.mixed_sample);
                        errors++;
                    end
                end
            end
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                mix_if.ready <= 1'b0;
            end
            else
                mix_if.ready <= steady || $urandom_range(99) >= IDLE_PCT;
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        errors                = 0;
        hold_requests         = 0;
        steady                = 1'b0;
        mix_sum               = '0;
        mix_heard             = 1'b0;
        foreach (gain_shadow[i])
            gain_shadow[i] = UNITY_GAIN;
        rst_n                 = 1'b0;
        samples_if.valid      = 1'b0;
        samples_if.mode       = MODE_MIX;
        samples_if.channel    = '0;
        samples_if.gain_value = '0;
        samples_if.sample     = '0;
        samples_if.present    = 1'b0;
        samples_if.last       = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_sample_frames(60);
        test_full_rate(30);
        test_output_stall(25);
        test_drain_between_frames(10);
        test_random_items(300);
        test_sample_frames(50);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending_mixes.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
